// ----- rtl/slbm_pkg.sv -----
// ----------------------------------------------------------------------------
// slbm_pkg
// Shared types, constants and arithmetic helpers of the LED bar meter.
// ----------------------------------------------------------------------------
package slbm_pkg;

	localparam int unsigned MAX_KEYS_DEF = 64;

	localparam logic [15:0] UNIT       = 16'hFFFF;
	localparam logic [9:0]  SMOOTH_MAX = 10'd1013;

	// reciprocal step of the gradient weight: 2 * UNIT
	localparam logic [16:0] GRAD_STEP = 17'd131070;
	localparam int unsigned DIV_STEPS = 17;

	// brightness = BRIGHT_BASE + ((BRIGHT_GAIN * u + 256) >> 9)
	localparam logic [15:0] BRIGHT_BASE = 16'd36044;
	localparam logic [14:0] BRIGHT_GAIN = 15'd29491;

	localparam logic [2:0] REG_SMOOTHING    = 3'd0;
	localparam logic [2:0] REG_INVERT       = 3'd1;
	localparam logic [2:0] REG_PULSE_ENABLE = 3'd2;
	localparam logic [2:0] REG_GRAD_LO      = 3'd3;
	localparam logic [2:0] REG_GRAD_MID     = 3'd4;
	localparam logic [2:0] REG_GRAD_HI      = 3'd5;
	localparam logic [2:0] REG_UNLIT        = 3'd6;
	localparam logic [2:0] REG_BAR_LENGTH   = 3'd7;

	localparam logic [23:0] GRAD_LO_RST    = 24'h00FF00;
	localparam logic [23:0] GRAD_MID_RST   = 24'hFFBF00;
	localparam logic [23:0] GRAD_HI_RST    = 24'hFF0000;
	localparam logic [23:0] UNLIT_RST      = 24'h000000;
	localparam logic [6:0]  BAR_LENGTH_RST = 7'd64;

	typedef struct packed {
		logic load;
		logic avg;
		logic fill;
		logic div_step;
		logic issue;
	} slbm_cmd_t;

	typedef struct packed {
		logic pipe_empty;
		logic last_key;
		logic adv;
	} slbm_sts_t;

	function automatic logic [8:0] quarter_sine(input logic [6:0] idx);
		logic [8:0] r;
		case (idx)
			7'd0:  r = 9'd0;   7'd1:  r = 9'd6;   7'd2:  r = 9'd13;  7'd3:  r = 9'd19;
			7'd4:  r = 9'd25;  7'd5:  r = 9'd31;  7'd6:  r = 9'd38;  7'd7:  r = 9'd44;
			7'd8:  r = 9'd50;  7'd9:  r = 9'd56;  7'd10: r = 9'd62;  7'd11: r = 9'd68;
			7'd12: r = 9'd74;  7'd13: r = 9'd80;  7'd14: r = 9'd86;  7'd15: r = 9'd92;
			7'd16: r = 9'd98;  7'd17: r = 9'd104; 7'd18: r = 9'd109; 7'd19: r = 9'd115;
			7'd20: r = 9'd121; 7'd21: r = 9'd126; 7'd22: r = 9'd132; 7'd23: r = 9'd137;
			7'd24: r = 9'd142; 7'd25: r = 9'd147; 7'd26: r = 9'd152; 7'd27: r = 9'd157;
			7'd28: r = 9'd162; 7'd29: r = 9'd167; 7'd30: r = 9'd172; 7'd31: r = 9'd177;
			7'd32: r = 9'd181; 7'd33: r = 9'd185; 7'd34: r = 9'd190; 7'd35: r = 9'd194;
			7'd36: r = 9'd198; 7'd37: r = 9'd202; 7'd38: r = 9'd206; 7'd39: r = 9'd209;
			7'd40: r = 9'd213; 7'd41: r = 9'd216; 7'd42: r = 9'd220; 7'd43: r = 9'd223;
			7'd44: r = 9'd226; 7'd45: r = 9'd229; 7'd46: r = 9'd231; 7'd47: r = 9'd234;
			7'd48: r = 9'd237; 7'd49: r = 9'd239; 7'd50: r = 9'd241; 7'd51: r = 9'd243;
			7'd52: r = 9'd245; 7'd53: r = 9'd247; 7'd54: r = 9'd248; 7'd55: r = 9'd250;
			7'd56: r = 9'd251; 7'd57: r = 9'd252; 7'd58: r = 9'd253; 7'd59: r = 9'd254;
			7'd60: r = 9'd255; 7'd61: r = 9'd255; 7'd62: r = 9'd256; 7'd63: r = 9'd256;
			7'd64: r = 9'd256;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// a*(1-w) + b*w in unit fractions, rounding offset included
	function automatic logic [23:0] mix_sum(input logic [7:0] a, input logic [7:0] b,
			input logic [15:0] w);
		logic [23:0] pa;
		logic [23:0] pb;
		logic [24:0] s;
		pa = 24'(a) * 24'(UNIT - w);
		pb = 24'(b) * 24'(w);
		s = 25'(pa) + 25'(pb) + 25'd32767;
		return s[23:0];
	endfunction

	// x / 65535 for x below 256 * 65535
	function automatic logic [7:0] div_unit(input logic [23:0] x);
		logic [7:0]  q0;
		logic [16:0] rem;
		q0 = x[23:16];
		rem = 17'(x[15:0]) + 17'(q0);
		return (rem >= 17'(UNIT)) ? q0 + 8'd1 : q0;
	endfunction

endpackage

// ----- rtl/slbm_ctrl.sv -----
// ----------------------------------------------------------------------------
// slbm_ctrl
// Sequencer: setup of average and brightness, gradient divider, key issue.
// ----------------------------------------------------------------------------
module slbm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output slbm_pkg::slbm_cmd_t cmd,
	input  slbm_pkg::slbm_sts_t sts
);
	import slbm_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_AVG   = 3'd1;
	localparam logic [2:0] ST_FILL  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_RUN   = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;

	localparam int CW = $clog2(DIV_STEPS);

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && (state_q == ST_IDLE);
		cmd.avg = (state_q == ST_AVG);
		cmd.fill = (state_q == ST_FILL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.issue = (state_q == ST_RUN) && sts.adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_AVG;
				end
				ST_AVG: state_q <= ST_FILL;
				ST_FILL: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(DIV_STEPS - 1)) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (cmd.issue && sts.last_key) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (sts.pipe_empty) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> sts.pipe_empty)
		else $error("idle with keys still in flight");

	a_last_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && sts.last_key) |=> (state_q == ST_DRAIN))
		else $error("last key issued without draining");

	a_drain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && !sts.pipe_empty) |=> (state_q == ST_DRAIN))
		else $error("left drain early");

endmodule

// ----- rtl/slbm_dp.sv -----
// ----------------------------------------------------------------------------
// slbm_dp
// Datapath: smoothing, brightness, serial gradient divider, key color pipe.
// ----------------------------------------------------------------------------
module slbm_dp #(
	parameter int unsigned MAX_KEYS = slbm_pkg::MAX_KEYS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  slbm_pkg::slbm_cmd_t cmd,
	output slbm_pkg::slbm_sts_t sts,
	input  logic [15:0]        level,
	input  logic               charging,
	input  logic [7:0]         pulse_phase,
	input  logic [9:0]         smoothing,
	input  logic               invert,
	input  logic               pulse_enable,
	input  logic [23:0]        grad_lo,
	input  logic [23:0]        grad_mid,
	input  logic [23:0]        grad_hi,
	input  logic [23:0]        unlit,
	input  logic [6:0]         bar_length,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         key_slot,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               last_key
);
	import slbm_pkg::*;

	localparam int NW = $clog2(MAX_KEYS + 1);
	localparam int FW = 16 + NW;

	// item setup
	logic [15:0]   level_q;
	logic          charging_q;
	logic [7:0]    phase_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] d_q;
	logic [15:0]   avg_q;
	logic          loaded_q;
	logic [15:0]   bright_q;
	logic [FW-1:0] filled_q;

	// divider and key counters
	logic [NW-1:0] div_rem_q;
	logic [16:0]   dvd_q;
	logic [16:0]   dq_q;
	logic [NW-1:0] i_q;
	logic [FW-1:0] base_q;
	logic [17:0]   gq_q;
	logic [NW-1:0] gr_q;

	// pipeline
	logic          v_s1, v_s2, v_s3, v_s4, out_v_q;
	logic [NW-1:0] slot_s1, slot_s2, slot_s3, slot_s4, slot_q;
	logic          last_s1, last_s2, last_s3, last_s4, last_q;
	logic [15:0]   f_s1, f_s2, f_s3, f_s4;
	logic [15:0]   w_s1;
	logic [23:0]   ca_s1, cb_s1;
	logic [2:0][23:0] x_s2, x_s3, x_s4;
	logic [23:0]   col_q;

	logic          adv;
	logic [NW-1:0] n_clamp;
	logic [15:0]   v_in;
	logic [9:0]    s_eff;
	logic [26:0]   avg_sum;
	logic [6:0]    sine_idx;
	logic [8:0]    mag;
	logic [9:0]    u;
	logic [24:0]   bright_prod;
	logic [NW:0]   rem_sh;
	logic [NW:0]   gr_sum;
	logic [FW-1:0] diff;
	logic [15:0]   f_c;
	logic [NW:0]   two_i;
	logic          seg_low;
	logic          n_one;
	logic [2:0][23:0] x2_c, x3_c, x4_c;
	logic [23:0]   col_c;

	assign adv = !out_v_q || !out_stall;

	always_comb begin
		if (bar_length == 7'd0) n_clamp = NW'(1);
		else if (32'(bar_length) > 32'(MAX_KEYS)) n_clamp = NW'(MAX_KEYS);
		else n_clamp = NW'(bar_length);
	end

	always_comb begin
		v_in = invert ? UNIT - level_q : level_q;
		s_eff = (smoothing > SMOOTH_MAX) ? SMOOTH_MAX : smoothing;
		avg_sum = 27'(avg_q) * 27'(s_eff) + 27'(v_in) * 27'(11'd1024 - 11'(s_eff))
			+ 27'd512;
		sine_idx = phase_q[6] ? 7'd64 - 7'(phase_q[5:0]) : 7'(phase_q[5:0]);
		mag = quarter_sine(sine_idx);
		u = phase_q[7] ? 10'd256 - 10'(mag) : 10'd256 + 10'(mag);
		bright_prod = 25'(BRIGHT_GAIN) * 25'(u) + 25'd256;
	end

	always_comb begin
		rem_sh = {div_rem_q, dvd_q[16]};
		gr_sum = (NW+1)'(gr_q) + (NW+1)'(div_rem_q);
		diff = filled_q - base_q;
		if (filled_q <= base_q) f_c = '0;
		else if (diff > FW'(UNIT)) f_c = UNIT;
		else f_c = diff[15:0];
		two_i = {i_q, 1'b0};
		seg_low = two_i <= (NW+1)'(d_q);
		n_one = (n_q == NW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
		end else if (cmd.avg) begin
			loaded_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			level_q <= level;
			charging_q <= charging;
			phase_q <= pulse_phase;
			n_q <= n_clamp;
			d_q <= n_clamp - NW'(1);
		end
		if (cmd.avg) begin
			avg_q <= loaded_q ? avg_sum[25:10] : v_in;
			bright_q <= (charging_q && pulse_enable) ? BRIGHT_BASE + 16'(bright_prod >> 9)
				: UNIT;
		end
		if (cmd.fill) begin
			filled_q <= FW'(avg_q) * FW'(n_q);
			i_q <= '0;
			base_q <= '0;
			gq_q <= '0;
			gr_q <= d_q >> 1;
			div_rem_q <= '0;
			dvd_q <= GRAD_STEP;
		end
		// restoring division of GRAD_STEP by d, one quotient bit a cycle
		if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			if (rem_sh >= (NW+1)'(d_q)) begin
				div_rem_q <= NW'(rem_sh - (NW+1)'(d_q));
				dq_q <= {dq_q[15:0], 1'b1};
			end else begin
				div_rem_q <= rem_sh[NW-1:0];
				dq_q <= {dq_q[15:0], 1'b0};
			end
		end
		// weight numerator grows by GRAD_STEP per key: quotient and remainder track it
		if (cmd.issue) begin
			i_q <= i_q + NW'(1);
			base_q <= base_q + FW'(UNIT);
			if (gr_sum >= (NW+1)'(d_q)) begin
				gr_q <= NW'(gr_sum - (NW+1)'(d_q));
				gq_q <= gq_q + 18'(dq_q) + 18'd1;
			end else begin
				gr_q <= gr_sum[NW-1:0];
				gq_q <= gq_q + 18'(dq_q);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			x2_c[c] = mix_sum(ca_s1[8*c +: 8], cb_s1[8*c +: 8], w_s1);
			x3_c[c] = mix_sum(unlit[8*c +: 8], div_unit(x_s2[c]), bright_q);
			x4_c[c] = mix_sum(unlit[8*c +: 8], div_unit(x_s3[c]), f_s3);
			col_c[8*c +: 8] = div_unit(x_s4[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_v_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slot_s1 <= i_q;
			last_s1 <= (i_q == n_q - NW'(1));
			f_s1 <= f_c;
			w_s1 <= seg_low ? gq_q[15:0] : 16'(gq_q - 18'(UNIT));
			ca_s1 <= (n_one || seg_low) ? grad_lo : grad_mid;
			cb_s1 <= n_one ? grad_lo : (seg_low ? grad_mid : grad_hi);

			slot_s2 <= slot_s1;
			last_s2 <= last_s1;
			f_s2 <= f_s1;
			x_s2 <= x2_c;

			slot_s3 <= slot_s2;
			last_s3 <= last_s2;
			f_s3 <= f_s2;
			x_s3 <= x3_c;

			slot_s4 <= slot_s3;
			last_s4 <= last_s3;
			f_s4 <= f_s3;
			x_s4 <= x4_c;

			slot_q <= slot_s4;
			last_q <= last_s4;
			col_q <= (f_s4 == 16'd0) ? unlit : col_c;
		end
	end

	assign sts.adv = adv;
	assign sts.last_key = (i_q == n_q - NW'(1));
	assign sts.pipe_empty = !v_s1 && !v_s2 && !v_s3 && !v_s4 && !out_v_q;

	assign out_valid = out_v_q;
	assign key_slot = 6'(slot_q);
	assign red = col_q[23:16];
	assign green = col_q[15:8];
	assign blue = col_q[7:0];
	assign last_key = last_q;

endmodule

// ----- rtl/smoothed_led_bar_meter_unit.sv -----
// ----------------------------------------------------------------------------
// smoothed_led_bar_meter_unit
// Smoothed meter reading rendered as a gradient LED bar, one key per beat.
// ----------------------------------------------------------------------------
// A reading is accepted only in idle; the sequencer then sets up average and
// brightness and runs the serial divider for the gradient step, and keys then
// issue one per cycle while the output is not stalled. The next reading waits
// until the last key has drained. Reset clears config to defaults and marks
// the average as not loaded, so the first reading loads the average directly.
module smoothed_led_bar_meter_unit #(
	parameter int unsigned MAX_KEYS = slbm_pkg::MAX_KEYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] level,
	input  logic        charging,
	input  logic [7:0]  pulse_phase,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  key_slot,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        last_key
);
	import slbm_pkg::*;

	logic [9:0]  smoothing_q;
	logic        invert_q;
	logic        pulse_enable_q;
	logic [23:0] grad_lo_q;
	logic [23:0] grad_mid_q;
	logic [23:0] grad_hi_q;
	logic [23:0] unlit_q;
	logic [6:0]  bar_length_q;

	slbm_cmd_t cmd;
	slbm_sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothing_q <= '0;
			invert_q <= 1'b0;
			pulse_enable_q <= 1'b0;
			grad_lo_q <= GRAD_LO_RST;
			grad_mid_q <= GRAD_MID_RST;
			grad_hi_q <= GRAD_HI_RST;
			unlit_q <= UNLIT_RST;
			bar_length_q <= BAR_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SMOOTHING:    smoothing_q <= cfg_data[9:0];
				REG_INVERT:       invert_q <= cfg_data[0];
				REG_PULSE_ENABLE: pulse_enable_q <= cfg_data[0];
				REG_GRAD_LO:      grad_lo_q <= cfg_data;
				REG_GRAD_MID:     grad_mid_q <= cfg_data;
				REG_GRAD_HI:      grad_hi_q <= cfg_data;
				REG_UNLIT:        unlit_q <= cfg_data;
				REG_BAR_LENGTH:   bar_length_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	slbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	slbm_dp #(
		.MAX_KEYS (MAX_KEYS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.level        (level),
		.charging     (charging),
		.pulse_phase  (pulse_phase),
		.smoothing    (smoothing_q),
		.invert       (invert_q),
		.pulse_enable (pulse_enable_q),
		.grad_lo      (grad_lo_q),
		.grad_mid     (grad_mid_q),
		.grad_hi      (grad_hi_q),
		.unlit        (unlit_q),
		.bar_length   (bar_length_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.key_slot     (key_slot),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.last_key     (last_key)
	);

endmodule
